// File: rtl/core/xxh64_pkg.sv
// ---------------------------------------------------------------------------
// xxh64_pkg
// Shared types, primes and helpers for the streaming XXH64 hasher.
// ---------------------------------------------------------------------------
`default_nettype none

package xxh64_pkg;

    localparam logic [63:0] PRIME1 = 64'h9E3779B185EBCA87;
    localparam logic [63:0] PRIME2 = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] PRIME3 = 64'h165667B19E3779F9;
    localparam logic [63:0] PRIME4 = 64'h85EBCA77C2B2AE63;
    localparam logic [63:0] PRIME5 = 64'h27D4EB2F165667C5;

    localparam int STRIPE_BYTES = 32;
    localparam int WORD_BYTES   = 8;
    localparam int LANES        = 4;

    // register index of the seed
    localparam logic REG_SEED = 1'b0;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,      // capture input transaction
        OP_INS_LO,    // place bytes that fit in the current stripe
        OP_INS_HI,    // place wrapped bytes, update fill
        OP_X_LANE,    // X = stripe lane[idx]
        OP_X_ACCSUM,  // X = rotl(acc[idx] + P, 31)
        OP_X_ACC,     // X = acc[idx]
        OP_X_PROT31,  // X = rotl(P, 31)
        OP_ACC_P,     // acc[idx] = P
        OP_MUL,       // P = X * K (multi-cycle)
        OP_MERGE0,    // h = rotl(a0,1) + rotl(a1,7)
        OP_MERGE1,    // h += rotl(a2,12) + rotl(a3,18)
        OP_SHORT,     // h = acc2 + P5
        OP_ADDLEN,    // h += length
        OP_HX_XOR,    // h ^= P, X = rot(h ^ P)
        OP_H_PADD,    // h = P + K, pos += pos_inc
        OP_X_TLANE,   // X = tail lane at pos
        OP_X_WORD4,   // X = tail 32-bit word at pos
        OP_X_BYTE,    // X = tail byte at pos
        OP_AV1,       // h ^= h >> 33, X = same
        OP_AV2,       // h = P ^ P >> 29, X = same
        OP_AV3,       // h = P ^ P >> 32
        OP_EMIT       // load output register, restart message
    } dp_op_t;

    typedef enum logic [1:0] {KM_P1, KM_P2, KM_P3, KM_P5} kmul_t;
    typedef enum logic [1:0] {KA_ZERO, KA_P3, KA_P4} kadd_t;
    typedef enum logic [1:0] {ROT_0, ROT_27, ROT_23, ROT_11} rot_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] idx;
        kmul_t      kmul;
        kadd_t      kadd;
        rot_t       rot;
        logic [3:0] pos_inc;
    } dp_cmd_t;

    typedef struct packed {
        logic wrap;      // stripe fills on this transaction
        logic last;
        logic long_msg;  // length >= 32
        logic rem_ge8;
        logic rem_ge4;
        logic rem_nz;
        logic mul_done;
        logic out_busy;
    } dp_stat_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_INS_LO, ST_F_XL, ST_F_XA, ST_F_WA, ST_INS_HI,
        ST_FIN, ST_G_M1, ST_G_XA, ST_G_R31, ST_G_XOR, ST_G_ADD,
        ST_SHORT, ST_LEN, ST_TAIL,
        ST_T8_X, ST_T8_R, ST_T8_XOR, ST_T8_ADD,
        ST_T4_X, ST_T4_XOR, ST_T4_ADD,
        ST_T1_X, ST_T1_XOR, ST_T1_ADD,
        ST_AV1, ST_AV2, ST_AV3, ST_EMIT, ST_MUL
    } ctrl_state_t;

    function automatic logic [63:0] kmul_value(kmul_t k);
        case (k)
            KM_P1:   return PRIME1;
            KM_P2:   return PRIME2;
            KM_P3:   return PRIME3;
            KM_P5:   return PRIME5;
            default: return PRIME1;
        endcase
    endfunction

    function automatic logic [63:0] kadd_value(kadd_t k);
        case (k)
            KA_P3:   return PRIME3;
            KA_P4:   return PRIME4;
            default: return 64'd0;
        endcase
    endfunction

    function automatic logic [63:0] rotl(logic [63:0] x, int r);
        return (x << r) | (x >> (64 - r));
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/xxh64_dp.sv
// ---------------------------------------------------------------------------
// xxh64_dp
// Datapath: seed, accumulators, stripe buffer, shared 32x32 multiplier.
// ---------------------------------------------------------------------------
`default_nettype none

module xxh64_dp (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire xxh64_pkg::dp_cmd_t cmd,
    output xxh64_pkg::dp_stat_t     stat,
    input  wire logic [63:0]        in_word,
    input  wire logic [3:0]         in_count,
    input  wire logic               in_last,
    input  wire logic               seed_we,
    input  wire logic [63:0]        seed_wdata,
    output logic [63:0]             seed_value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [63:0]             out_hash
);

    logic [63:0] seed_reg, seed_next;
    logic [63:0] acc_reg [4];
    logic [63:0] acc_next [4];
    logic [7:0]  sbuf_reg [32];
    logic [7:0]  sbuf_next [32];
    logic [4:0]  bb_reg, bb_next;
    logic [63:0] len_reg, len_next;
    logic [4:0]  pos_reg, pos_next;
    logic [63:0] word_reg, word_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        last_reg, last_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] p_reg, p_next;
    logic [63:0] h_reg, h_next;
    logic [63:0] pp0_reg, pp0_next;
    logic [31:0] mid_reg, mid_next;
    logic [1:0]  mcnt_reg, mcnt_next;
    logic [63:0] out_reg, out_next;
    logic        ov_reg, ov_next;

    logic [63:0] lane_w [4];
    logic [63:0] kmul_w, hx_w, hx_rot, av_w;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [5:0]  fill_sum;
    logic [4:0]  rem_w;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            for (int b = 0; b < 8; b++) begin
                lane_w[k][8*b +: 8] = sbuf_reg[8*k + b];
            end
        end
    end

    assign kmul_w   = xxh64_pkg::kmul_value(cmd.kmul);
    assign mul_a    = (mcnt_reg == 2'd2) ? x_reg[63:32] : x_reg[31:0];
    assign mul_b    = (mcnt_reg == 2'd1) ? kmul_w[63:32] : kmul_w[31:0];
    assign prod     = mul_a * mul_b;
    assign fill_sum = {1'b0, bb_reg} + {2'b00, cnt_reg};
    assign rem_w    = bb_reg - pos_reg;
    assign hx_w     = h_reg ^ p_reg;

    always_comb begin
        case (cmd.rot)
            xxh64_pkg::ROT_27: hx_rot = xxh64_pkg::rotl(hx_w, 27);
            xxh64_pkg::ROT_23: hx_rot = xxh64_pkg::rotl(hx_w, 23);
            xxh64_pkg::ROT_11: hx_rot = xxh64_pkg::rotl(hx_w, 11);
            default:           hx_rot = hx_w;
        endcase
    end

    always_comb begin
        logic [5:0] p6;
        seed_next = seed_reg;
        for (int k = 0; k < 4; k++) acc_next[k] = acc_reg[k];
        for (int j = 0; j < 32; j++) sbuf_next[j] = sbuf_reg[j];
        bb_next   = bb_reg;
        len_next  = len_reg;
        pos_next  = pos_reg;
        word_next = word_reg;
        cnt_next  = cnt_reg;
        last_next = last_reg;
        x_next    = x_reg;
        p_next    = p_reg;
        h_next    = h_reg;
        pp0_next  = pp0_reg;
        mid_next  = mid_reg;
        mcnt_next = 2'd0;
        out_next  = out_reg;
        ov_next   = ov_reg && !out_ready;
        av_w      = 64'd0;
        p6        = 6'd0;

        case (cmd.op)
            xxh64_pkg::OP_LOAD: begin
                word_next = in_word;
                cnt_next  = (in_count > 4'd8) ? 4'd8 : in_count;
                last_next = in_last;
            end
            xxh64_pkg::OP_INS_LO: begin
                len_next = len_reg + {60'd0, cnt_reg};
                for (int i = 0; i < 8; i++) begin
                    p6 = {1'b0, bb_reg} + 6'(i);
                    if (4'(i) < cnt_reg && !p6[5]) sbuf_next[p6[4:0]] = word_reg[8*i +: 8];
                end
            end
            xxh64_pkg::OP_INS_HI: begin
                for (int i = 0; i < 8; i++) begin
                    p6 = {1'b0, bb_reg} + 6'(i);
                    if (4'(i) < cnt_reg && p6[5]) sbuf_next[p6[4:0]] = word_reg[8*i +: 8];
                end
                bb_next = fill_sum[4:0];
            end
            xxh64_pkg::OP_X_LANE:   x_next = lane_w[cmd.idx];
            xxh64_pkg::OP_X_ACCSUM: x_next = xxh64_pkg::rotl(acc_reg[cmd.idx] + p_reg, 31);
            xxh64_pkg::OP_X_ACC:    x_next = acc_reg[cmd.idx];
            xxh64_pkg::OP_X_PROT31: x_next = xxh64_pkg::rotl(p_reg, 31);
            xxh64_pkg::OP_ACC_P:    acc_next[cmd.idx] = p_reg;
            xxh64_pkg::OP_MUL: begin
                mcnt_next = mcnt_reg + 2'd1;
                case (mcnt_reg)
                    2'd0:    pp0_next = prod;
                    2'd1:    mid_next = prod[31:0];
                    2'd2:    mid_next = mid_reg + prod[31:0];
                    default: begin
                        p_next    = pp0_reg + {mid_reg, 32'd0};
                        mcnt_next = 2'd0;
                    end
                endcase
            end
            xxh64_pkg::OP_MERGE0:
                h_next = xxh64_pkg::rotl(acc_reg[0], 1) + xxh64_pkg::rotl(acc_reg[1], 7);
            xxh64_pkg::OP_MERGE1:
                h_next = h_reg + xxh64_pkg::rotl(acc_reg[2], 12)
                       + xxh64_pkg::rotl(acc_reg[3], 18);
            xxh64_pkg::OP_SHORT:  h_next = acc_reg[2] + xxh64_pkg::PRIME5;
            xxh64_pkg::OP_ADDLEN: h_next = h_reg + len_reg;
            xxh64_pkg::OP_HX_XOR: begin
                h_next = hx_w;
                x_next = hx_rot;
            end
            xxh64_pkg::OP_H_PADD: begin
                h_next   = p_reg + xxh64_pkg::kadd_value(cmd.kadd);
                pos_next = pos_reg + {1'b0, cmd.pos_inc};
            end
            xxh64_pkg::OP_X_TLANE: x_next = lane_w[pos_reg[4:3]];
            xxh64_pkg::OP_X_WORD4: x_next = {32'd0, lane_w[pos_reg[4:3]][31:0]};
            xxh64_pkg::OP_X_BYTE:  x_next = {56'd0, sbuf_reg[pos_reg]};
            xxh64_pkg::OP_AV1: begin
                av_w   = h_reg ^ (h_reg >> 33);
                h_next = av_w;
                x_next = av_w;
            end
            xxh64_pkg::OP_AV2: begin
                av_w   = p_reg ^ (p_reg >> 29);
                h_next = av_w;
                x_next = av_w;
            end
            xxh64_pkg::OP_AV3: h_next = p_reg ^ (p_reg >> 32);
            xxh64_pkg::OP_EMIT: begin
                out_next = h_reg;
                ov_next  = 1'b1;
            end
            default: ;
        endcase

        if (seed_we) seed_next = seed_wdata;

        // start a new message after a digest or a seed write
        if (seed_we || cmd.op == xxh64_pkg::OP_EMIT) begin
            acc_next[0] = seed_next + xxh64_pkg::PRIME1 + xxh64_pkg::PRIME2;
            acc_next[1] = seed_next + xxh64_pkg::PRIME2;
            acc_next[2] = seed_next;
            acc_next[3] = seed_next - xxh64_pkg::PRIME1;
            bb_next     = 5'd0;
            len_next    = 64'd0;
            pos_next    = 5'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg   <= 64'd0;
            acc_reg[0] <= xxh64_pkg::PRIME1 + xxh64_pkg::PRIME2;
            acc_reg[1] <= xxh64_pkg::PRIME2;
            acc_reg[2] <= 64'd0;
            acc_reg[3] <= 64'd0 - xxh64_pkg::PRIME1;
            bb_reg     <= 5'd0;
            len_reg    <= 64'd0;
            pos_reg    <= 5'd0;
            mcnt_reg   <= 2'd0;
            ov_reg     <= 1'b0;
        end else begin
            seed_reg <= seed_next;
            for (int k = 0; k < 4; k++) acc_reg[k] <= acc_next[k];
            bb_reg   <= bb_next;
            len_reg  <= len_next;
            pos_reg  <= pos_next;
            mcnt_reg <= mcnt_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < 32; j++) sbuf_reg[j] <= sbuf_next[j];
        word_reg <= word_next;
        cnt_reg  <= cnt_next;
        last_reg <= last_next;
        x_reg    <= x_next;
        p_reg    <= p_next;
        h_reg    <= h_next;
        pp0_reg  <= pp0_next;
        mid_reg  <= mid_next;
        out_reg  <= out_next;
    end

    assign stat.wrap     = fill_sum[5];
    assign stat.last     = last_reg;
    assign stat.long_msg = (len_reg >= 64'd32);
    assign stat.rem_ge8  = (rem_w >= 5'd8);
    assign stat.rem_ge4  = (rem_w >= 5'd4);
    assign stat.rem_nz   = (rem_w != 5'd0);
    assign stat.mul_done = (mcnt_reg == 2'd3);
    assign stat.out_busy = ov_reg;

    assign seed_value = seed_reg;
    assign out_valid  = ov_reg;
    assign out_hash   = out_reg;

endmodule

`default_nettype wire

// File: rtl/core/xxh64_ctrl.sv
// ---------------------------------------------------------------------------
// xxh64_ctrl
// Sequencer: stripe folds, digest merge, tail folds and avalanche.
// ---------------------------------------------------------------------------
`default_nettype none

module xxh64_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire xxh64_pkg::dp_stat_t stat,
    output xxh64_pkg::dp_cmd_t       cmd
);

    xxh64_pkg::ctrl_state_t state_reg, state_next, ret_reg, ret_next;
    xxh64_pkg::kmul_t       km_reg, km_next;
    logic [1:0]             idx_reg, idx_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= xxh64_pkg::ST_IDLE;
            ret_reg   <= xxh64_pkg::ST_IDLE;
            km_reg    <= xxh64_pkg::KM_P1;
            idx_reg   <= 2'd0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            km_reg    <= km_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        km_next     = km_reg;
        idx_next    = idx_reg;
        in_ready    = 1'b0;
        cmd.op      = xxh64_pkg::OP_NONE;
        cmd.idx     = idx_reg;
        cmd.kmul    = km_reg;
        cmd.kadd    = xxh64_pkg::KA_ZERO;
        cmd.rot     = xxh64_pkg::ROT_0;
        cmd.pos_inc = 4'd0;

        case (state_reg)
            xxh64_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.op     = xxh64_pkg::OP_LOAD;
                    state_next = xxh64_pkg::ST_INS_LO;
                end
            end
            xxh64_pkg::ST_INS_LO: begin
                cmd.op   = xxh64_pkg::OP_INS_LO;
                idx_next = 2'd0;
                state_next = stat.wrap ? xxh64_pkg::ST_F_XL : xxh64_pkg::ST_INS_HI;
            end
            // stripe fold, one lane per pass
            xxh64_pkg::ST_F_XL: begin
                cmd.op     = xxh64_pkg::OP_X_LANE;
                km_next    = xxh64_pkg::KM_P2;
                ret_next   = xxh64_pkg::ST_F_XA;
                state_next = xxh64_pkg::ST_MUL;
            end
            xxh64_pkg::ST_F_XA: begin
                cmd.op     = xxh64_pkg::OP_X_ACCSUM;
                km_next    = xxh64_pkg::KM_P1;
                ret_next   = xxh64_pkg::ST_F_WA;
                state_next = xxh64_pkg::ST_MUL;
            end
            xxh64_pkg::ST_F_WA: begin
                cmd.op   = xxh64_pkg::OP_ACC_P;
                idx_next = idx_reg + 2'd1;
                state_next = (idx_reg == 2'd3) ? xxh64_pkg::ST_INS_HI : xxh64_pkg::ST_F_XL;
            end
            xxh64_pkg::ST_INS_HI: begin
                cmd.op     = xxh64_pkg::OP_INS_HI;
                state_next = stat.last ? xxh64_pkg::ST_FIN : xxh64_pkg::ST_IDLE;
            end
            xxh64_pkg::ST_FIN: begin
                idx_next = 2'd0;
                if (stat.long_msg) begin
                    cmd.op     = xxh64_pkg::OP_MERGE0;
                    state_next = xxh64_pkg::ST_G_M1;
                end else begin
                    state_next = xxh64_pkg::ST_SHORT;
                end
            end
            xxh64_pkg::ST_G_M1: begin
                cmd.op     = xxh64_pkg::OP_MERGE1;
                state_next = xxh64_pkg::ST_G_XA;
            end
            // merge of each accumulator
            xxh64_pkg::ST_G_XA: begin
                cmd.op     = xxh64_pkg::OP_X_ACC;
                km_next    = xxh64_pkg::KM_P2;
                ret_next   = xxh64_pkg::ST_G_R31;
                state_next = xxh64_pkg::ST_MUL;
            end
            xxh64_pkg::ST_G_R31: begin
                cmd.op     = xxh64_pkg::OP_X_PROT31;
                km_next    = xxh64_pkg::KM_P1;
                ret_next   = xxh64_pkg::ST_G_XOR;
                state_next = xxh64_pkg::ST_MUL;
            end
            xxh64_pkg::ST_G_XOR: begin
                cmd.op     = xxh64_pkg::OP_HX_XOR;
                km_next    = xxh64_pkg::KM_P1;
                ret_next   = xxh64_pkg::ST_G_ADD;
                state_next = xxh64_pkg::ST_MUL;
            end
            xxh64_pkg::ST_G_ADD: begin
                cmd.op   = xxh64_pkg::OP_H_PADD;
                cmd.kadd = xxh64_pkg::KA_P4;
                idx_next = idx_reg + 2'd1;
                state_next = (idx_reg == 2'd3) ? xxh64_pkg::ST_LEN : xxh64_pkg::ST_G_XA;
            end
            xxh64_pkg::ST_SHORT: begin
                cmd.op     = xxh64_pkg::OP_SHORT;
                state_next = xxh64_pkg::ST_LEN;
            end
            xxh64_pkg::ST_LEN: begin
                cmd.op     = xxh64_pkg::OP_ADDLEN;
                state_next = xxh64_pkg::ST_TAIL;
            end
            xxh64_pkg::ST_TAIL: begin
                if (stat.rem_ge8)     state_next = xxh64_pkg::ST_T8_X;
                else if (stat.rem_ge4) state_next = xxh64_pkg::ST_T4_X;
                else if (stat.rem_nz)  state_next = xxh64_pkg::ST_T1_X;
                else                   state_next = xxh64_pkg::ST_AV1;
            end
            // 8-byte tail step
            xxh64_pkg::ST_T8_X: begin
                cmd.op     = xxh64_pkg::OP_X_TLANE;
                km_next    = xxh64_pkg::KM_P2;
                ret_next   = xxh64_pkg::ST_T8_R;
                state_next = xxh64_pkg::ST_MUL;
            end
            xxh64_pkg::ST_T8_R: begin
                cmd.op     = xxh64_pkg::OP_X_PROT31;
                km_next    = xxh64_pkg::KM_P1;
                ret_next   = xxh64_pkg::ST_T8_XOR;
                state_next = xxh64_pkg::ST_MUL;
            end
            xxh64_pkg::ST_T8_XOR: begin
                cmd.op     = xxh64_pkg::OP_HX_XOR;
                cmd.rot    = xxh64_pkg::ROT_27;
                km_next    = xxh64_pkg::KM_P1;
                ret_next   = xxh64_pkg::ST_T8_ADD;
                state_next = xxh64_pkg::ST_MUL;
            end
            xxh64_pkg::ST_T8_ADD: begin
                cmd.op      = xxh64_pkg::OP_H_PADD;
                cmd.kadd    = xxh64_pkg::KA_P4;
                cmd.pos_inc = 4'd8;
                state_next  = xxh64_pkg::ST_TAIL;
            end
            // 4-byte tail step
            xxh64_pkg::ST_T4_X: begin
                cmd.op     = xxh64_pkg::OP_X_WORD4;
                km_next    = xxh64_pkg::KM_P1;
                ret_next   = xxh64_pkg::ST_T4_XOR;
                state_next = xxh64_pkg::ST_MUL;
            end
            xxh64_pkg::ST_T4_XOR: begin
                cmd.op     = xxh64_pkg::OP_HX_XOR;
                cmd.rot    = xxh64_pkg::ROT_23;
                km_next    = xxh64_pkg::KM_P2;
                ret_next   = xxh64_pkg::ST_T4_ADD;
                state_next = xxh64_pkg::ST_MUL;
            end
            xxh64_pkg::ST_T4_ADD: begin
                cmd.op      = xxh64_pkg::OP_H_PADD;
                cmd.kadd    = xxh64_pkg::KA_P3;
                cmd.pos_inc = 4'd4;
                state_next  = xxh64_pkg::ST_TAIL;
            end
            // 1-byte tail step
            xxh64_pkg::ST_T1_X: begin
                cmd.op     = xxh64_pkg::OP_X_BYTE;
                km_next    = xxh64_pkg::KM_P5;
                ret_next   = xxh64_pkg::ST_T1_XOR;
                state_next = xxh64_pkg::ST_MUL;
            end
            xxh64_pkg::ST_T1_XOR: begin
                cmd.op     = xxh64_pkg::OP_HX_XOR;
                cmd.rot    = xxh64_pkg::ROT_11;
                km_next    = xxh64_pkg::KM_P1;
                ret_next   = xxh64_pkg::ST_T1_ADD;
                state_next = xxh64_pkg::ST_MUL;
            end
            xxh64_pkg::ST_T1_ADD: begin
                cmd.op      = xxh64_pkg::OP_H_PADD;
                cmd.pos_inc = 4'd1;
                state_next  = xxh64_pkg::ST_TAIL;
            end
            // avalanche
            xxh64_pkg::ST_AV1: begin
                cmd.op     = xxh64_pkg::OP_AV1;
                km_next    = xxh64_pkg::KM_P2;
                ret_next   = xxh64_pkg::ST_AV2;
                state_next = xxh64_pkg::ST_MUL;
            end
            xxh64_pkg::ST_AV2: begin
                cmd.op     = xxh64_pkg::OP_AV2;
                km_next    = xxh64_pkg::KM_P3;
                ret_next   = xxh64_pkg::ST_AV3;
                state_next = xxh64_pkg::ST_MUL;
            end
            xxh64_pkg::ST_AV3: begin
                cmd.op     = xxh64_pkg::OP_AV3;
                state_next = xxh64_pkg::ST_EMIT;
            end
            xxh64_pkg::ST_EMIT: begin
                if (!stat.out_busy) begin
                    cmd.op     = xxh64_pkg::OP_EMIT;
                    state_next = xxh64_pkg::ST_IDLE;
                end
            end
            xxh64_pkg::ST_MUL: begin
                cmd.op = xxh64_pkg::OP_MUL;
                if (stat.mul_done) state_next = ret_reg;
            end
            default: state_next = xxh64_pkg::ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/xxhash64_streaming.sv
// ---------------------------------------------------------------------------
// xxhash64_streaming
// Streaming XXH64 hasher with an APB seed register.
// ---------------------------------------------------------------------------
// Input: each word is loaded and placed in the stripe buffer before the
//   next is accepted; a word that completes a stripe adds four lane
//   rounds, two multiplies each on the shared 32x32 multiplier.
// Last word: the digest follows the merge (messages of 32 bytes or
//   more), the 8-, 4- and 1-byte tail steps and the avalanche.
// Reset: synchronous active-low aresetn; seed 0, empty message.
// ---------------------------------------------------------------------------
`default_nettype none

module xxhash64_streaming (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input transactions
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [63:0] s_data_word,
    input  wire logic [3:0]  s_byte_count,
    input  wire logic        s_last,
    // digest transactions
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_hash_value,
    // APB register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    xxh64_pkg::dp_cmd_t  cmd;
    xxh64_pkg::dp_stat_t stat;
    logic [63:0]         seed_value;
    logic                seed_we;

    // registers are 64-bit, at 8-byte strides; paddr[3] selects the index
    assign pready  = 1'b1;
    assign seed_we = psel && penable && pwrite && (paddr[3] == xxh64_pkg::REG_SEED);
    assign prdata  = (paddr[3] == xxh64_pkg::REG_SEED) ? seed_value : 64'd0;

    // sequencer
    xxh64_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // state, stripe buffer, multiplier, output register
    xxh64_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_word    (s_data_word),
        .in_count   (s_byte_count),
        .in_last    (s_last),
        .seed_we    (seed_we),
        .seed_wdata (pwdata),
        .seed_value (seed_value),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_hash   (m_hash_value)
    );

endmodule

`default_nettype wire

// File: tb/xxhash64_streaming_checker.sv
// ---------------------------------------------------------------------------
// xxhash64_streaming_checker
// Watches both channels and the seed register port, keeps its own XXH64
// state and compares every digest transaction with the oldest expected one.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module xxhash64_streaming_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [63:0] s_data_word,
    input  wire logic [3:0]  s_byte_count,
    input  wire logic        s_last,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [63:0] m_hash_value,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    input  wire logic        pready,
    output int               error_count,
    output int               pending_digests
);

    logic [63:0] seed_q;
    logic [63:0] acc [4];
    logic [7:0]  stripe [32];
    int unsigned fill;
    logic [63:0] msg_len;
    logic [63:0] digest_q [$];

    function automatic logic [63:0] rot64(logic [63:0] x, int r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic logic [63:0] lane_mix(logic [63:0] a, logic [63:0] lane);
        a = a + lane * xxh64_pkg::PRIME2;
        return rot64(a, 31) * xxh64_pkg::PRIME1;
    endfunction

    function automatic logic [63:0] stripe_le(int p, int n);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < n; i++) v |= 64'(stripe[p + i]) << (8 * i);
        return v;
    endfunction

    task automatic restart_message();
        acc[0] = seed_q + xxh64_pkg::PRIME1 + xxh64_pkg::PRIME2;
        acc[1] = seed_q + xxh64_pkg::PRIME2;
        acc[2] = seed_q;
        acc[3] = seed_q - xxh64_pkg::PRIME1;
        fill = 0;
        msg_len = '0;
    endtask

    function automatic logic [63:0] finish_digest();
        logic [63:0] h;
        int p;
        int rem;
        p = 0;
        rem = fill;
        if (msg_len >= 64'd32) begin
            h = rot64(acc[0], 1) + rot64(acc[1], 7) + rot64(acc[2], 12) + rot64(acc[3], 18);
            for (int i = 0; i < 4; i++) begin
                h ^= lane_mix(64'd0, acc[i]);
                h = h * xxh64_pkg::PRIME1 + xxh64_pkg::PRIME4;
            end
        end else begin
            h = acc[2] + xxh64_pkg::PRIME5;
        end
        h += msg_len;
        while (rem >= 8) begin
            h ^= lane_mix(64'd0, stripe_le(p, 8));
            h = rot64(h, 27) * xxh64_pkg::PRIME1 + xxh64_pkg::PRIME4;
            p += 8;
            rem -= 8;
        end
        if (rem >= 4) begin
            h ^= stripe_le(p, 4) * xxh64_pkg::PRIME1;
            h = rot64(h, 23) * xxh64_pkg::PRIME2 + xxh64_pkg::PRIME3;
            p += 4;
            rem -= 4;
        end
        while (rem > 0) begin
            h ^= 64'(stripe[p]) * xxh64_pkg::PRIME5;
            h = rot64(h, 11) * xxh64_pkg::PRIME1;
            p++;
            rem--;
        end
        h ^= h >> 33;
        h *= xxh64_pkg::PRIME2;
        h ^= h >> 29;
        h *= xxh64_pkg::PRIME3;
        h ^= h >> 32;
        return h;
    endfunction

    task automatic absorb_word(logic [63:0] w, logic [3:0] cnt, logic lst);
        int n;
        n = (cnt > 4'd8) ? 8 : int'(cnt);
        msg_len += 64'(n);
        for (int i = 0; i < n; i++) begin
            stripe[fill] = w[8*i +: 8];
            fill++;
            if (fill == 32) begin
                for (int l = 0; l < 4; l++) acc[l] = lane_mix(acc[l], stripe_le(8 * l, 8));
                fill = 0;
            end
        end
        if (lst) begin
            digest_q.push_back(finish_digest());
            restart_message();
        end
    endtask

    task automatic report_mismatch(string what);
        $display("mismatch: %s", what);
        error_count++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            seed_q = '0;
            restart_message();
            digest_q.delete();
            error_count = 0;
        end else begin
            if (psel && penable && pwrite && pready
                && paddr == {xxh64_pkg::REG_SEED, 3'b000}) begin
                seed_q = pwdata;
                restart_message();
            end
            if (s_valid && s_ready) absorb_word(s_data_word, s_byte_count, s_last);
            if (m_valid && m_ready) begin
                if (digest_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected digest %h", m_hash_value));
                end else begin
                    logic [63:0] want;
                    want = digest_q.pop_front();
                    if (m_hash_value !== want)
                        report_mismatch($sformatf("hash_value %h want %h", m_hash_value, want));
                end
            end
        end
        pending_digests = digest_q.size();
    end

endmodule

// File: tb/xxhash64_streaming_tb.sv
// ---------------------------------------------------------------------------
// xxhash64_streaming_tb
// Drives messages of assorted lengths and seeds into the hasher with random
// gaps and back-pressure; the checker predicts and compares each digest.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module xxhash64_streaming_tb;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_data_word = '0;
    logic [3:0]  s_byte_count = '0;
    logic        s_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_hash_value;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    int error_count;
    int pending_digests;
    int idle_cycles = 0;
    bit rx_free_run = 1'b0;   // when set, m_ready is held high

    localparam int WATCHDOG_LIMIT = 20000;

    always #2 aclk = ~aclk;

    xxhash64_streaming DUT (.*);

    xxhash64_streaming_checker checker_i (.*);

    // Random gap length: mostly short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Receiver back-pressure.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_free_run) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 9) < 6);
        end
    end

    // Watchdog: cycles with no transaction on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Valid stays high after the transaction until the next word or a gap
    // replaces it, so valid gets one update per edge.
    task automatic send_word(logic [63:0] w, logic [3:0] cnt, logic lst);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_data_word  <= w;
        s_byte_count <= cnt;
        s_last       <= lst;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Waits for every digest, then lets the tail latency of the block pass.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_digests != 0) @(posedge aclk);
        repeat (250) @(posedge aclk);
    endtask

    task automatic write_seed(logic [63:0] v);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {xxh64_pkg::REG_SEED, 3'b000};
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Message of nbytes bytes: full words, then a last word of 0..8 bytes.
    task automatic send_message(int nbytes, bit extreme);
        int full;
        int tail;
        full = nbytes / 8;
        tail = nbytes % 8;
        if (tail == 0 && full > 0 && $urandom_range(0, 1)) begin
            full--;
            tail = 8;
        end
        for (int i = 0; i < full; i++)
            send_word(extreme ? {64{1'b1}} : rand64(), 4'd8, 1'b0);
        send_word(extreme ? {64{1'b1}} : rand64(), 4'(tail), 1'b1);
    endtask

    int sent;
    int r;

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty message, short tails, stripe edges, extreme data.
        send_word('0, 4'd0, 1'b1);
        send_message(1, 1'b1);
        send_message(4, 1'b0);
        send_message(7, 1'b0);
        send_message(31, 1'b1);
        send_message(32, 1'b0);
        send_message(33, 1'b1);
        // byte counts above eight count as eight
        send_word(rand64(), 4'd15, 1'b0);
        send_word(rand64(), 4'd9, 1'b1);
        // short word in the middle of a message
        send_word(rand64(), 4'd3, 1'b0);
        send_word(rand64(), 4'd8, 1'b1);
        write_seed({64{1'b1}});
        send_message(40, 1'b1);
        send_word('0, 4'd0, 1'b1);
        // seed write in the middle of a message discards it
        send_word(rand64(), 4'd8, 1'b0);
        send_word(rand64(), 4'd8, 1'b0);
        write_seed(64'd1);
        send_message(12, 1'b0);

        // Random messages, mostly short, some spanning several stripes.
        sent = 0;
        while (sent < 400) begin
            r = $urandom_range(0, 99);
            if (r < 4) write_seed(rand64());
            else if (r < 6) write_seed($urandom_range(0, 1) ? 64'd0 : {64{1'b1}});
            else if (r < 8) drain();
            if ($urandom_range(0, 9) == 0) begin
                send_word(rand64(), 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
                sent++;
            end else begin
                int len;
                len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 40)
                                                 : $urandom_range(41, 140);
                send_message(len, 1'b0);
                sent += len / 8 + 1;
            end
        end

        rx_free_run = 1'b1;
        drain();
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/xxh64_pkg.sv
rtl/core/xxh64_dp.sv
rtl/core/xxh64_ctrl.sv
rtl/core/xxhash64_streaming.sv
tb/xxhash64_streaming_checker.sv
tb/xxhash64_streaming_tb.sv
